@@ rtl/qte_pkg.sv @@
package qte_pkg;

  localparam int CordicSteps = 16;
  localparam int AtanLen     = 24;
  localparam int Steps       = (CordicSteps < AtanLen) ? CordicSteps : AtanLen;

  localparam int InW   = 16;
  localparam int OpW   = 34;
  localparam int SW    = 31;
  localparam int RemW  = 61;
  localparam int NormW = 35;
  localparam int CW    = 38;
  localparam int AccW  = 26;
  localparam int RndW  = AccW - 9;
  localparam int ShW   = 6;
  localparam int NormTop = 33;

  localparam int IsqrtLat = 2 + SW;
  localparam int AtanLat  = Steps + 4;
  localparam int PipeLen  = 3 + IsqrtLat + AtanLat + 1;

  localparam logic signed [AccW-1:0] Deg90 = AccW'(5898240);
  localparam logic signed [AccW-1:0] RndHalf = AccW'(256);
  localparam logic signed [OpW-1:0] OneQ30 = OpW'(64'sd1073741824);
  localparam logic signed [RndW-1:0] LimRoll  = RndW'(23040);
  localparam logic signed [RndW-1:0] LimPitch = RndW'(11520);

  localparam logic [21:0] AtanFine [AtanLen] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666, 22'd29335, 22'd14668, 22'd7334, 22'd3667, 22'd1833,
    22'd917, 22'd458, 22'd229, 22'd115, 22'd57, 22'd29,
    22'd14, 22'd7, 22'd4, 22'd2, 22'd1, 22'd0
  };

  typedef struct packed {
    logic signed [OpW-1:0] r11;
    logic signed [OpW-1:0] r12;
    logic signed [OpW-1:0] r31;
    logic signed [OpW-1:0] r32;
    logic signed [SW:0]    s;
  } terms_t;

endpackage

@@ rtl/qte_isqrt.sv @@
module qte_isqrt (
  input  logic                     clk_i,
  input  logic [qte_pkg::SW-1:0]   a_i,
  output logic [qte_pkg::SW-1:0]   c_o
);

  localparam int SW   = qte_pkg::SW;
  localparam int RemW = qte_pkg::RemW;

  logic [14:0] hh_a, hh_b;
  logic [29:0] pp_hh_q;
  logic [30:0] pp_hl_q;
  logic [31:0] pp_ll_q;
  logic [RemW:0] sq;

  logic [RemW-1:0] rem_q  [SW+1];
  logic [SW-1:0]   root_q [SW+1];

  assign hh_a = a_i[SW-1:16];
  assign hh_b = a_i[SW-1:16];

  always_ff @(posedge clk_i) begin
    pp_hh_q <= hh_a * hh_b;
    pp_hl_q <= hh_a * a_i[15:0];
    pp_ll_q <= a_i[15:0] * a_i[15:0];
  end

  assign sq = ((RemW+1)'(pp_hh_q) << 32) + ((RemW+1)'(pp_hl_q) << 17)
            + (RemW+1)'(pp_ll_q);

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= RemW'(((RemW+1)'(1) << 60) - sq);
    root_q[0] <= '0;
  end

  for (genvar k = 0; k < SW; k++) begin : g_bit
    localparam int B = SW - 1 - k;
    logic [RemW:0]   trial;
    logic [RemW-1:0] rem_d;
    logic [SW-1:0]   root_d;

    always_comb begin
      trial = ((RemW+1)'(root_q[k]) << (B + 1)) + ((RemW+1)'(1) << (2 * B));
      if ((RemW+1)'(rem_q[k]) >= trial) begin
        rem_d  = RemW'((RemW+1)'(rem_q[k]) - trial);
        root_d = root_q[k] | (SW'(1) << B);
      end else begin
        rem_d  = rem_q[k];
        root_d = root_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      rem_q[k+1]  <= rem_d;
      root_q[k+1] <= root_d;
    end
  end

  assign c_o = root_q[SW];

endmodule

@@ rtl/qte_atan2.sv @@
module qte_atan2 (
  input  logic                              clk_i,
  input  logic signed [qte_pkg::OpW-1:0]    y_i,
  input  logic signed [qte_pkg::OpW-1:0]    x_i,
  output logic signed [qte_pkg::RndW-1:0]   ang_o
);

  localparam int OpW   = qte_pkg::OpW;
  localparam int NormW = qte_pkg::NormW;
  localparam int CW    = qte_pkg::CW;
  localparam int AccW  = qte_pkg::AccW;
  localparam int RndW  = qte_pkg::RndW;
  localparam int ShW   = qte_pkg::ShW;
  localparam int Steps = qte_pkg::Steps;

  logic [OpW-1:0] mag_x, mag_y, mag_or;
  logic [ShW-1:0] msb;

  logic signed [OpW-1:0]   x1_q, y1_q;
  logic [ShW-1:0]          sh1_q;
  logic                    zero1_q;
  logic signed [NormW-1:0] x2_q, y2_q;
  logic                    zero2_q;

  logic signed [CW-1:0]   cx_q [Steps+1];
  logic signed [CW-1:0]   cy_q [Steps+1];
  logic signed [AccW-1:0] ca_q [Steps+1];
  logic                   cz_q [Steps+1];

  logic signed [AccW-1:0] rnd_sum;
  logic signed [RndW-1:0] ang_q;

  always_comb begin
    mag_x  = x_i[OpW-1] ? OpW'(-x_i) : OpW'(x_i);
    mag_y  = y_i[OpW-1] ? OpW'(-y_i) : OpW'(y_i);
    mag_or = mag_x | mag_y;
    msb    = '0;
    for (int i = 0; i < OpW; i++) begin
      if (mag_or[i]) begin
        msb = ShW'(i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x1_q    <= x_i;
    y1_q    <= y_i;
    sh1_q   <= ShW'(qte_pkg::NormTop) - msb;
    zero1_q <= (mag_or == '0);
  end

  always_ff @(posedge clk_i) begin
    x2_q    <= NormW'(x1_q) <<< sh1_q;
    y2_q    <= NormW'(y1_q) <<< sh1_q;
    zero2_q <= zero1_q;
  end

  always_ff @(posedge clk_i) begin
    cz_q[0] <= zero2_q;
    if (x2_q < 0) begin
      if (y2_q >= 0) begin
        cx_q[0] <= CW'(y2_q);
        cy_q[0] <= -CW'(x2_q);
        ca_q[0] <= qte_pkg::Deg90;
      end else begin
        cx_q[0] <= -CW'(y2_q);
        cy_q[0] <= CW'(x2_q);
        ca_q[0] <= -qte_pkg::Deg90;
      end
    end else begin
      cx_q[0] <= CW'(x2_q);
      cy_q[0] <= CW'(y2_q);
      ca_q[0] <= '0;
    end
  end

  for (genvar i = 0; i < Steps; i++) begin : g_step
    logic signed [CW-1:0]   xs, ys;
    logic signed [AccW-1:0] step_ang;

    assign xs       = cx_q[i] >>> i;
    assign ys       = cy_q[i] >>> i;
    assign step_ang = AccW'(qte_pkg::AtanFine[i]);

    always_ff @(posedge clk_i) begin
      cz_q[i+1] <= cz_q[i];
      if (cy_q[i] > 0) begin
        cx_q[i+1] <= cx_q[i] + ys;
        cy_q[i+1] <= cy_q[i] - xs;
        ca_q[i+1] <= ca_q[i] + step_ang;
      end else begin
        cx_q[i+1] <= cx_q[i] - ys;
        cy_q[i+1] <= cy_q[i] + xs;
        ca_q[i+1] <= ca_q[i] - step_ang;
      end
    end
  end

  assign rnd_sum = ca_q[Steps] + qte_pkg::RndHalf;

  always_ff @(posedge clk_i) begin
    ang_q <= cz_q[Steps] ? '0 : RndW'(rnd_sum >>> 9);
  end

  assign ang_o = ang_q;

endmodule

@@ rtl/quaternion_to_euler_angles.sv @@
// Quaternion to ZYX Tait-Bryan angles, fully pipelined.
// A command beat is taken at a rising edge where start_i is high; busy_o is
// always low, so a new quaternion can be issued in every cycle.
// Inputs quat_w_i .. quat_z_i are signed Q1.15. Outputs roll_deg_o,
// pitch_deg_o and yaw_deg_o are degrees with 7 fraction bits.
// Each command produces one result beat, shown for one cycle with valid_o
// high. A command passes through the product, sum and clamp stages, the
// squaring, remainder and 31 bit stages of the integer square root for the
// pitch cosine, and the normalize, quadrant, CORDIC, rounding and limit stages.
// Throughput is one beat per cycle.
// Reset clears only the valid pipeline, so no beats leave the block until
// new commands arrive. The receiver cannot stall; results are never held.
module quaternion_to_euler_angles (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  output logic                       busy_o,
  input  logic signed [15:0]         quat_w_i,
  input  logic signed [15:0]         quat_x_i,
  input  logic signed [15:0]         quat_y_i,
  input  logic signed [15:0]         quat_z_i,
  output logic                       valid_o,
  output logic signed [15:0]         roll_deg_o,
  output logic signed [14:0]         pitch_deg_o,
  output logic signed [15:0]         yaw_deg_o
);

  localparam int OpW      = qte_pkg::OpW;
  localparam int SW       = qte_pkg::SW;
  localparam int RndW     = qte_pkg::RndW;
  localparam int IsqrtLat = qte_pkg::IsqrtLat;
  localparam int PipeLen  = qte_pkg::PipeLen;

  logic [PipeLen-1:0] vld_q;

  logic signed [31:0] ww_q, xx_q, yy_q, zz_q, xy_q, wz_q, wy_q, xz_q, yz_q, wx_q;
  qte_pkg::terms_t    term_q;
  logic signed [OpW-1:0] r21_q;
  logic signed [OpW-1:0] s_clamp;
  logic [SW-1:0]      a_q;
  logic [SW-1:0]      c_w;

  qte_pkg::terms_t    dly_q [IsqrtLat+1];

  logic signed [RndW-1:0] roll_w, pitch_w, yaw_w;

  assign busy_o = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeLen-2:0], start_i};
    end
  end

  always_ff @(posedge clk_i) begin
    ww_q <= quat_w_i * quat_w_i;
    xx_q <= quat_x_i * quat_x_i;
    yy_q <= quat_y_i * quat_y_i;
    zz_q <= quat_z_i * quat_z_i;
    xy_q <= quat_x_i * quat_y_i;
    wz_q <= quat_w_i * quat_z_i;
    wy_q <= quat_w_i * quat_y_i;
    xz_q <= quat_x_i * quat_z_i;
    yz_q <= quat_y_i * quat_z_i;
    wx_q <= quat_w_i * quat_x_i;
  end

  always_ff @(posedge clk_i) begin
    term_q.r11 <= (OpW'(xy_q) + OpW'(wz_q)) <<< 1;
    term_q.r12 <= OpW'(ww_q) + OpW'(xx_q) - OpW'(yy_q) - OpW'(zz_q);
    term_q.r31 <= (OpW'(yz_q) + OpW'(wx_q)) <<< 1;
    term_q.r32 <= OpW'(ww_q) - OpW'(xx_q) - OpW'(yy_q) + OpW'(zz_q);
    term_q.s   <= '0;
    r21_q      <= (OpW'(wy_q) - OpW'(xz_q)) <<< 1;
  end

  always_comb begin
    if (r21_q > qte_pkg::OneQ30) begin
      s_clamp = qte_pkg::OneQ30;
    end else if (r21_q < -qte_pkg::OneQ30) begin
      s_clamp = -qte_pkg::OneQ30;
    end else begin
      s_clamp = r21_q;
    end
  end

  always_ff @(posedge clk_i) begin
    dly_q[0].r11 <= term_q.r11;
    dly_q[0].r12 <= term_q.r12;
    dly_q[0].r31 <= term_q.r31;
    dly_q[0].r32 <= term_q.r32;
    dly_q[0].s   <= (SW+1)'(s_clamp);
    a_q          <= s_clamp[OpW-1] ? SW'(-s_clamp) : SW'(s_clamp);
  end

  for (genvar j = 1; j <= IsqrtLat; j++) begin : g_dly
    always_ff @(posedge clk_i) begin
      dly_q[j] <= dly_q[j-1];
    end
  end

  qte_isqrt u_isqrt (
    .clk_i (clk_i),
    .a_i   (a_q),
    .c_o   (c_w)
  );

  qte_atan2 u_roll (
    .clk_i (clk_i),
    .y_i   (dly_q[IsqrtLat].r31),
    .x_i   (dly_q[IsqrtLat].r32),
    .ang_o (roll_w)
  );

  qte_atan2 u_pitch (
    .clk_i (clk_i),
    .y_i   (OpW'(dly_q[IsqrtLat].s)),
    .x_i   (OpW'(c_w)),
    .ang_o (pitch_w)
  );

  qte_atan2 u_yaw (
    .clk_i (clk_i),
    .y_i   (dly_q[IsqrtLat].r11),
    .x_i   (dly_q[IsqrtLat].r12),
    .ang_o (yaw_w)
  );

  always_ff @(posedge clk_i) begin
    if (roll_w > qte_pkg::LimRoll) begin
      roll_deg_o <= 16'(qte_pkg::LimRoll);
    end else if (roll_w < -qte_pkg::LimRoll) begin
      roll_deg_o <= 16'(-qte_pkg::LimRoll);
    end else begin
      roll_deg_o <= 16'(roll_w);
    end

    if (pitch_w > qte_pkg::LimPitch) begin
      pitch_deg_o <= 15'(qte_pkg::LimPitch);
    end else if (pitch_w < -qte_pkg::LimPitch) begin
      pitch_deg_o <= 15'(-qte_pkg::LimPitch);
    end else begin
      pitch_deg_o <= 15'(pitch_w);
    end

    if (yaw_w > qte_pkg::LimRoll) begin
      yaw_deg_o <= 16'(qte_pkg::LimRoll);
    end else if (yaw_w < -qte_pkg::LimRoll) begin
      yaw_deg_o <= 16'(-qte_pkg::LimRoll);
    end else begin
      yaw_deg_o <= 16'(yaw_w);
    end
  end

  assign valid_o = vld_q[PipeLen-1];

endmodule
